>>> rtl/vau_pkg.sv
package vau_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int LANES       = 4;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int MAG_W       = PROD_W - FRAC_W;
    localparam int TERM_W      = MAG_W + 1;
    localparam int DOT_W       = TERM_W + 2;
    localparam int DIVD_W      = WORD_W + FRAC_W;
    localparam int RAD_W       = 2 * WORD_W;
    localparam int ROOT_W      = WORD_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = DIVD_W;
    localparam int OP_W        = 4;
    localparam int IN_DATA_W   = 9 * WORD_W;
    localparam int OUT_DATA_W  = ((5 * WORD_W + 2 + 7) / 8) * 8;

    typedef logic [WORD_W-1:0]             t_word;
    typedef logic [LANES-1:0][WORD_W-1:0]  t_vec;
    typedef logic [OP_W-1:0]               t_op;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam t_op OP_ADD  = 4'd0;
    localparam t_op OP_SUB  = 4'd1;
    localparam t_op OP_MUL  = 4'd2;
    localparam t_op OP_DIV  = 4'd3;
    localparam t_op OP_ADDS = 4'd4;
    localparam t_op OP_SUBS = 4'd5;
    localparam t_op OP_MULS = 4'd6;
    localparam t_op OP_DIVS = 4'd7;
    localparam t_op OP_NEG  = 4'd8;
    localparam t_op OP_DOT  = 4'd9;
    localparam t_op OP_LEN  = 4'd10;
    localparam t_op OP_NORM = 4'd11;
    localparam t_op OP_CMP  = 4'd12;

    // side data riding alongside the square root stages
    typedef struct packed {
        t_op   op;
        t_vec  a;
        t_vec  rhs;
        t_vec  vec;
        t_word dot;
        logic  eq;
        logic  big;
    } t_side_a;

    // side data riding alongside the divider stages
    typedef struct packed {
        t_op   op;
        t_vec  vec;
        t_word sc;
        logic  eq;
    } t_side_b;

    function automatic t_word mag_of(input t_word v);
        mag_of = v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_word sat_wide(input logic [WORD_W:0] v);
        if (v[WORD_W] != v[WORD_W-1]) begin
            sat_wide = v[WORD_W] ? WORD_MIN : WORD_MAX;
        end else begin
            sat_wide = v[WORD_W-1:0];
        end
    endfunction

    function automatic t_word sat_dot(input logic [DOT_W-1:0] v);
        if ((v[DOT_W-1:WORD_W-1] == '0) || (&v[DOT_W-1:WORD_W-1])) begin
            sat_dot = v[WORD_W-1:0];
        end else begin
            sat_dot = v[DOT_W-1] ? WORD_MIN : WORD_MAX;
        end
    endfunction

endpackage

>>> rtl/vau_mul_lane.sv
module vau_mul_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  vau_pkg::t_word                  i_a,
    input  vau_pkg::t_word                  i_b,
    output logic [vau_pkg::TERM_W-1:0]      o_term,
    output vau_pkg::t_word                  o_sat
);

    logic [vau_pkg::PROD_W-1:0] r_prod;
    logic                       r_neg;
    logic [vau_pkg::PROD_W-1:0] rnd;
    logic [vau_pkg::MAG_W-1:0]  mag;
    logic                       mag_over;
    logic [vau_pkg::TERM_W-1:0] n_term;
    vau_pkg::t_word             n_sat;
    logic [vau_pkg::TERM_W-1:0] r_term;
    vau_pkg::t_word             r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= vau_pkg::PROD_W'(vau_pkg::mag_of(i_a))
                    * vau_pkg::PROD_W'(vau_pkg::mag_of(i_b));
            r_neg  <= i_a[vau_pkg::WORD_W-1] ^ i_b[vau_pkg::WORD_W-1];
        end
    end

    // round half away from zero on the magnitude
    always_comb begin
        rnd      = r_prod + (vau_pkg::PROD_W'(1) << (vau_pkg::FRAC_W - 1));
        mag      = rnd[vau_pkg::PROD_W-1:vau_pkg::FRAC_W];
        n_term   = r_neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
        mag_over = (mag[vau_pkg::MAG_W-1:vau_pkg::WORD_W] != '0);
        if (r_neg) begin
            if (mag_over || (mag[vau_pkg::WORD_W-1] && (mag[vau_pkg::WORD_W-2:0] != '0))) begin
                n_sat = vau_pkg::WORD_MIN;
            end else begin
                n_sat = ~mag[vau_pkg::WORD_W-1:0] + 1'b1;
            end
        end else begin
            if (mag_over || mag[vau_pkg::WORD_W-1]) begin
                n_sat = vau_pkg::WORD_MAX;
            end else begin
                n_sat = mag[vau_pkg::WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
            r_sat  <= n_sat;
        end
    end

    assign o_term = r_term;
    assign o_sat  = r_sat;

endmodule

>>> rtl/vau_sqrt_lane.sv
module vau_sqrt_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [vau_pkg::RAD_W-1:0]       i_rad,
    output logic [vau_pkg::ROOT_W-1:0]      o_root
);

    localparam int N = vau_pkg::SQRT_STAGES;

    logic [vau_pkg::REM_W-1:0]  r_rem  [N];
    logic [vau_pkg::ROOT_W-1:0] r_root [N];
    logic [vau_pkg::RAD_W-1:0]  r_rad  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [vau_pkg::REM_W-1:0]  rem_in;
        logic [vau_pkg::ROOT_W-1:0] root_in;
        logic [vau_pkg::RAD_W-1:0]  rad_in;
        logic [vau_pkg::REM_W+1:0]  cur;
        logic [vau_pkg::REM_W+1:0]  trial;
        logic [vau_pkg::REM_W+1:0]  diff;
        logic                       ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        // one result bit per stage, two radicand bits brought down
        assign cur   = {rem_in, rad_in[vau_pkg::RAD_W-1:vau_pkg::RAD_W-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[vau_pkg::REM_W-1:0] : cur[vau_pkg::REM_W-1:0];
                r_root[k] <= {root_in[vau_pkg::ROOT_W-2:0], ge};
                r_rad[k]  <= {rad_in[vau_pkg::RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

>>> rtl/vau_div_lane.sv
module vau_div_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  vau_pkg::t_word  i_dvd,
    input  vau_pkg::t_word  i_dvs,
    output vau_pkg::t_word  o_quo,
    output logic            o_zero
);

    localparam int N = vau_pkg::DIV_STAGES;
    localparam int W = vau_pkg::WORD_W;
    localparam int D = vau_pkg::DIVD_W;

    logic [W-2:0]   r_rem  [N];
    logic [D-1:0]   r_num  [N];
    logic [D-1:0]   r_quo  [N];
    vau_pkg::t_word r_dvs  [N];
    logic           r_neg  [N];
    logic           r_dneg [N];
    logic           r_dnz  [N];

    logic [D-1:0]   q;
    logic           q_big;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [W-2:0]   rem_in;
        logic [D-1:0]   num_in;
        logic [D-1:0]   quo_in;
        vau_pkg::t_word dvs_in;
        logic           neg_in;
        logic           dneg_in;
        logic           dnz_in;
        logic [W-1:0]   cur;
        logic [W-1:0]   diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = {vau_pkg::mag_of(i_dvd), vau_pkg::FRAC_W'(0)};
            assign quo_in  = '0;
            assign dvs_in  = vau_pkg::mag_of(i_dvs);
            assign neg_in  = i_dvd[W-1] ^ i_dvs[W-1];
            assign dneg_in = i_dvd[W-1];
            assign dnz_in  = (i_dvd != '0);
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign quo_in  = r_quo[k-1];
            assign dvs_in  = r_dvs[k-1];
            assign neg_in  = r_neg[k-1];
            assign dneg_in = r_dneg[k-1];
            assign dnz_in  = r_dnz[k-1];
        end

        // restoring step: remainder stays below the divisor, so W-1 bits hold it
        assign cur  = {rem_in, num_in[D-1]};
        assign ge   = (cur >= dvs_in);
        assign diff = cur - dvs_in;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[W-2:0] : cur[W-2:0];
                r_num[k]  <= {num_in[D-2:0], 1'b0};
                r_quo[k]  <= {quo_in[D-2:0], ge};
                r_dvs[k]  <= dvs_in;
                r_neg[k]  <= neg_in;
                r_dneg[k] <= dneg_in;
                r_dnz[k]  <= dnz_in;
            end
        end
    end

    assign q      = r_quo[N-1];
    assign q_big  = (q[D-1:W] != '0);
    assign o_zero = (r_dvs[N-1] == '0);

    always_comb begin
        if (o_zero) begin
            if (!r_dnz[N-1]) begin
                o_quo = '0;
            end else begin
                o_quo = r_dneg[N-1] ? vau_pkg::WORD_MIN : vau_pkg::WORD_MAX;
            end
        end else if (r_neg[N-1]) begin
            if (q_big || (q[W-1] && (q[W-2:0] != '0))) begin
                o_quo = vau_pkg::WORD_MIN;
            end else begin
                o_quo = ~q[W-1:0] + 1'b1;
            end
        end else begin
            if (q_big || q[W-1]) begin
                o_quo = vau_pkg::WORD_MAX;
            end else begin
                o_quo = q[W-1:0];
            end
        end
    end

endmodule

>>> rtl/vec4_arithmetic_unit.sv
// Four-component vector ALU on signed Q16.16 words. One request enters per cycle
// and each gives exactly one result, in order, through 85 register stages: input
// register, two multiplier stages, the dot sum, 32 square-root stages and 48 divider
// stages (one quotient bit each), then the output register. Every opcode takes the full
// depth, so results never reorder. The four lanes each hold a multiplier and a
// divider; one square-root pipe serves length and normalize. A stalled output
// holds the whole pipe, so o_s_tready follows i_m_tready while a result waits.
module vec4_arithmetic_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in
    input  logic [vau_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // opcode
    input  logic [vau_pkg::OP_W-1:0]            i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // r_x, r_y, r_z, r_w, scalar_out, equal_flag, zero_divide, zero pad
    output logic [vau_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int W  = vau_pkg::WORD_W;
    localparam int L  = vau_pkg::LANES;
    localparam int NS = vau_pkg::SQRT_STAGES;
    localparam int ND = vau_pkg::DIV_STAGES;

    logic en;

    logic r1_valid, r2_valid, r3_valid, r4_valid, r_out_valid;
    logic [NS-1:0] r_va;
    logic [ND-1:0] r_vb;

    vau_pkg::t_op   r1_op;
    vau_pkg::t_vec  r1_a, r1_b;
    vau_pkg::t_word r1_s;

    vau_pkg::t_op   r2_op, r3_op;
    vau_pkg::t_vec  r2_a, r2_rhs, r2_simple, r3_a, r3_rhs, r3_vec;
    logic           r2_eq, r3_eq;

    vau_pkg::t_side_a                  r4_side;
    logic [vau_pkg::RAD_W-1:0]         r4_rad;
    vau_pkg::t_side_a                  r_dly_a [NS];
    vau_pkg::t_side_b                  r_dly_b [ND];

    vau_pkg::t_vec  rhs, mopd, n_simple, mul_sat, quo, dvs;
    logic [L-1:0][vau_pkg::TERM_W-1:0] term;
    logic [L-1:0]   zero;
    logic [vau_pkg::DOT_W-1:0] dot;
    logic [vau_pkg::ROOT_W-1:0] root;
    vau_pkg::t_side_a sa;
    vau_pkg::t_side_b sb, n_side_b;
    vau_pkg::t_word len;

    vau_pkg::t_vec  n_vec;
    logic           n_zero;
    logic [vau_pkg::OUT_DATA_W-1:0] n_out, r_out;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_va        <= '0;
            r_vb        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_s_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_va        <= {r_va[NS-2:0], r4_valid};
            r_vb        <= {r_vb[ND-2:0], r_va[NS-1]};
            r_out_valid <= r_vb[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= i_s_tuser;
            r1_a  <= i_s_tdata[L*W-1:0];
            r1_b  <= i_s_tdata[2*L*W-1:L*W];
            r1_s  <= i_s_tdata[2*L*W+W-1:2*L*W];
        end
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            rhs[i] = r1_op[2] ? r1_s : r1_b[i];
            if (r1_op == vau_pkg::OP_DOT) begin
                mopd[i] = r1_b[i];
            end else if (r1_op inside {vau_pkg::OP_LEN, vau_pkg::OP_NORM}) begin
                mopd[i] = r1_a[i];
            end else begin
                mopd[i] = rhs[i];
            end
            case (r1_op)
                vau_pkg::OP_ADD, vau_pkg::OP_ADDS:
                    n_simple[i] = vau_pkg::sat_wide({r1_a[i][W-1], r1_a[i]}
                                                  + {rhs[i][W-1], rhs[i]});
                vau_pkg::OP_SUB, vau_pkg::OP_SUBS:
                    n_simple[i] = vau_pkg::sat_wide({r1_a[i][W-1], r1_a[i]}
                                                  - {rhs[i][W-1], rhs[i]});
                vau_pkg::OP_NEG:
                    n_simple[i] = vau_pkg::sat_wide((W+1)'(0) - {r1_a[i][W-1], r1_a[i]});
                default:
                    n_simple[i] = '0;
            endcase
        end
    end

    for (genvar i = 0; i < L; i++) begin : g_mul
        vau_mul_lane u_mul (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_a    (r1_a[i]),
            .i_b    (mopd[i]),
            .o_term (term[i]),
            .o_sat  (mul_sat[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op     <= r1_op;
            r2_a      <= r1_a;
            r2_rhs    <= rhs;
            r2_simple <= n_simple;
            r2_eq     <= (r1_op == vau_pkg::OP_CMP) && (r1_a == r1_b);
            r3_op     <= r2_op;
            r3_a      <= r2_a;
            r3_rhs    <= r2_rhs;
            r3_vec    <= r2_simple;
            r3_eq     <= r2_eq;
        end
    end

    // product results replace the add/sub slot for the multiply opcodes
    always_comb begin
        dot = '0;
        for (int i = 0; i < L; i++) begin
            dot = dot + {{(vau_pkg::DOT_W-vau_pkg::TERM_W){term[i][vau_pkg::TERM_W-1]}},
                         term[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side.op  <= r3_op;
            r4_side.a   <= r3_a;
            r4_side.rhs <= r3_rhs;
            r4_side.vec <= (r3_op inside {vau_pkg::OP_MUL, vau_pkg::OP_MULS}) ? mul_sat
                                                                              : r3_vec;
            r4_side.dot <= vau_pkg::sat_dot(dot);
            r4_side.eq  <= r3_eq;
            // self dot beyond 2^48 cannot be scaled; length saturates
            r4_side.big <= (dot[vau_pkg::DOT_W-1:2*W-vau_pkg::FRAC_W] != '0);
            r4_rad      <= {dot[2*W-vau_pkg::FRAC_W-1:0], vau_pkg::FRAC_W'(0)};
        end
    end

    vau_sqrt_lane u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_rad),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_a[0] <= r4_side;
            for (int k = 1; k < NS; k++) begin
                r_dly_a[k] <= r_dly_a[k-1];
            end
        end
    end

    assign sa  = r_dly_a[NS-1];
    assign len = (sa.big || root[vau_pkg::ROOT_W-1]) ? vau_pkg::WORD_MAX : root;

    always_comb begin
        for (int i = 0; i < L; i++) begin
            dvs[i] = (sa.op == vau_pkg::OP_NORM) ? len : sa.rhs[i];
        end
        n_side_b.op  = sa.op;
        n_side_b.vec = sa.vec;
        n_side_b.eq  = sa.eq;
        if (sa.op == vau_pkg::OP_DOT) begin
            n_side_b.sc = sa.dot;
        end else if (sa.op inside {vau_pkg::OP_LEN, vau_pkg::OP_NORM}) begin
            n_side_b.sc = len;
        end else begin
            n_side_b.sc = '0;
        end
    end

    for (genvar i = 0; i < L; i++) begin : g_div
        vau_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dvd  (sa.a[i]),
            .i_dvs  (dvs[i]),
            .o_quo  (quo[i]),
            .o_zero (zero[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_b[0] <= n_side_b;
            for (int k = 1; k < ND; k++) begin
                r_dly_b[k] <= r_dly_b[k-1];
            end
        end
    end

    // merge lanes into the result request
    assign sb = r_dly_b[ND-1];

    always_comb begin
        if (sb.op inside {vau_pkg::OP_DIV, vau_pkg::OP_DIVS, vau_pkg::OP_NORM}) begin
            n_vec  = quo;
            n_zero = |zero;
        end else begin
            n_vec  = sb.vec;
            n_zero = 1'b0;
        end
        n_out = {(vau_pkg::OUT_DATA_W - L*W - W - 2)'(0), n_zero, sb.eq, sb.sc, n_vec};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule
